[rtl/core/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants of the color run detector
// Color codes, result layout and the control bundle passed to each lane.
// ----------------------------------------------------------------------------
package cbd_pkg;

	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned SIZE_W   = 7;
	localparam int unsigned CENTER_W = 6;

	localparam logic [CHAN_W-1:0] THRESH_RESET = 8'd250;

	typedef enum logic [1:0] {
		COLOR_RED   = 2'd0,
		COLOR_GREEN = 2'd1,
		COLOR_BLUE  = 2'd2,
		COLOR_NONE  = 2'd3
	} color_t;

	// packed from the lowest bit up: red_size, green_size, blue_size,
	// red_center, green_center, blue_center
	typedef struct packed {
		logic [CENTER_W-1:0] blue_center;
		logic [CENTER_W-1:0] green_center;
		logic [CENTER_W-1:0] red_center;
		logic [SIZE_W-1:0]   blue_size;
		logic [SIZE_W-1:0]   green_size;
		logic [SIZE_W-1:0]   red_size;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);
	localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;

	typedef struct packed {
		logic step;    // item accepted this cycle
		logic clear;   // item ends the row
		logic bright;  // channel at or above threshold
		logic extend;  // continues the current run when bright
	} lane_ctrl_t;

endpackage

[rtl/core/cbd_lane.sv]
// ----------------------------------------------------------------------------
// cbd_lane: run tracker for one color
// Keeps the current run and the longest run of the row with its center.
// ----------------------------------------------------------------------------
module cbd_lane #(
	parameter int unsigned MAX_ROW_WIDTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cbd_pkg::lane_ctrl_t                  ctrl,
	input  logic [$clog2(MAX_ROW_WIDTH)-1:0]     col,
	output logic [$clog2(MAX_ROW_WIDTH+1)-1:0]   best_size_nxt,
	output logic [$clog2(MAX_ROW_WIDTH)-1:0]     best_center_nxt
);

	localparam int unsigned CW = $clog2(MAX_ROW_WIDTH);
	localparam int unsigned LW = $clog2(MAX_ROW_WIDTH + 1);
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_ROW_WIDTH);

	logic [LW-1:0] run_len_q;
	logic [CW-1:0] first_q;
	logic [CW-1:0] last_q;
	logic [LW-1:0] best_size_q;
	logic [CW-1:0] best_center_q;

	logic [LW-1:0] run_len_n;
	logic [CW-1:0] first_n;
	logic [CW-1:0] last_n;
	logic [CW:0]   span_sum;

	always_comb begin
		run_len_n = run_len_q;
		first_n   = first_q;
		last_n    = last_q;
		if (ctrl.bright) begin
			if (ctrl.extend) begin
				if (run_len_q < MAX_LEN) begin
					run_len_n = run_len_q + LW'(1);
				end
				if (col > last_q) begin
					last_n = col;
				end
				if (col < first_q) begin
					first_n = col;
				end
			end else begin
				run_len_n = LW'(1);
				first_n   = col;
				last_n    = col;
			end
		end
		span_sum        = {1'b0, first_n} + {1'b0, last_n};
		best_size_nxt   = best_size_q;
		best_center_nxt = best_center_q;
		if (ctrl.bright && (best_size_q < run_len_n)) begin
			best_size_nxt   = run_len_n;
			best_center_nxt = span_sum[CW:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q     <= '0;
			best_size_q   <= '0;
			best_center_q <= '0;
		end else if (ctrl.step) begin
			if (ctrl.clear) begin
				run_len_q     <= '0;
				best_size_q   <= '0;
				best_center_q <= '0;
			end else begin
				run_len_q     <= run_len_n;
				best_size_q   <= best_size_nxt;
				best_center_q <= best_center_nxt;
			end
		end
	end

	// run columns are read only after a restart wrote them in the same row
	always_ff @(posedge clk) begin
		if (ctrl.step && ctrl.bright) begin
			first_q <= first_n;
			last_q  <= last_n;
		end
	end

endmodule

[rtl/core/cbd_out_buf.sv]
// ----------------------------------------------------------------------------
// cbd_out_buf: result register with skid stage
// Holds up to two results so the input side keeps moving under back-pressure.
// ----------------------------------------------------------------------------
module cbd_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cbd_pkg::result_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output cbd_pkg::result_t  out_data
);

	logic             out_valid_q;
	logic             skid_valid_q;
	cbd_pkg::result_t out_q;
	cbd_pkg::result_t skid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_valid) begin
				out_q <= in_data;
			end
		end else if (in_valid && in_ready) begin
			skid_q <= in_data;
		end
	end

endmodule

[rtl/core/color_run_blob_detector.sv]
// ----------------------------------------------------------------------------
// color_run_blob_detector: per-row longest color run and its center
// Streams RGB pixels of a scan row and reports, per color, the longest run
// and its center column on the last pixel of the row.
// ----------------------------------------------------------------------------
// One pixel is taken on every clock while s_tready is high. Each pixel updates
// the three color lanes in the same cycle it is accepted: a channel at or above
// the threshold makes the pixel that color; of several bright channels all but
// the lowest restart, the lowest continuing if it was the last color seen, and
// the highest becomes the last color seen. The pixel flagged by s_tlast produces
// one result and clears all row state, so the first pixel of the next row may
// follow directly. Results pass through an output register and a skid stage:
// s_tready drops only when two results are waiting on m_tready, so back-pressure
// stalls the input only while the sink holds off beyond that. Columns past
// MAX_ROW_WIDTH all count as the last column and run lengths saturate at
// MAX_ROW_WIDTH; sizes and centers are cut to 7 and 6 bits on the output.
// The threshold register resets to 250 and should be written only while the
// block is idle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module color_run_blob_detector #(
	parameter int unsigned MAX_ROW_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: intensity_threshold
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	// pixel input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic        s_tlast,   // last_in_row
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	// red_size[6:0], green_size[13:7], blue_size[20:14], red_center[26:21],
	// green_center[32:27], blue_center[38:33], zero pad [39]
	output logic [cbd_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int unsigned CW = $clog2(MAX_ROW_WIDTH);
	localparam int unsigned LW = $clog2(MAX_ROW_WIDTH + 1);
	localparam logic [LW-1:0] MAX_CNT = LW'(MAX_ROW_WIDTH);
	localparam logic [CW-1:0] LAST_COL = CW'(MAX_ROW_WIDTH - 1);

	logic [cbd_pkg::CHAN_W-1:0] thresh_q;
	logic [LW-1:0]              col_cnt_q;
	cbd_pkg::color_t            last_color_q;

	logic                       accept;
	logic [CW-1:0]              col;
	logic                       br_r, br_g, br_b;
	cbd_pkg::lane_ctrl_t        ctrl_r, ctrl_g, ctrl_b;
	cbd_pkg::color_t            last_color_n;

	logic [LW-1:0]              size_r, size_g, size_b;
	logic [CW-1:0]              center_r, center_g, center_b;

	cbd_pkg::result_t           res_in;
	cbd_pkg::result_t           res_out;
	logic                       buf_ready;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = buf_ready;

	// hold the column at the last one once the row runs past its width
	assign col = (col_cnt_q < MAX_CNT) ? col_cnt_q[CW-1:0] : LAST_COL;

	assign br_r = s_tdata[7:0]   >= thresh_q;
	assign br_g = s_tdata[15:8]  >= thresh_q;
	assign br_b = s_tdata[23:16] >= thresh_q;

	// a color continues its run only if no earlier bright color of the same
	// pixel has taken over as last color
	always_comb begin
		ctrl_r = '{step: accept, clear: s_tlast, bright: br_r,
			extend: (last_color_q == cbd_pkg::COLOR_RED)};
		ctrl_g = '{step: accept, clear: s_tlast, bright: br_g,
			extend: !br_r && (last_color_q == cbd_pkg::COLOR_GREEN)};
		ctrl_b = '{step: accept, clear: s_tlast, bright: br_b,
			extend: !br_r && !br_g && (last_color_q == cbd_pkg::COLOR_BLUE)};
	end

	// last color ends as the highest bright color, or none
	always_comb begin
		priority if (br_b) begin
			last_color_n = cbd_pkg::COLOR_BLUE;
		end else if (br_g) begin
			last_color_n = cbd_pkg::COLOR_GREEN;
		end else if (br_r) begin
			last_color_n = cbd_pkg::COLOR_RED;
		end else begin
			last_color_n = cbd_pkg::COLOR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= cbd_pkg::THRESH_RESET;
		end else if (cfg_wen) begin
			thresh_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q    <= '0;
			last_color_q <= cbd_pkg::COLOR_NONE;
		end else if (accept) begin
			if (s_tlast) begin
				col_cnt_q    <= '0;
				last_color_q <= cbd_pkg::COLOR_NONE;
			end else begin
				if (col_cnt_q < MAX_CNT) begin
					col_cnt_q <= col_cnt_q + LW'(1);
				end
				last_color_q <= last_color_n;
			end
		end
	end

	cbd_lane #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_lane_r (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl_r),
		.col             (col),
		.best_size_nxt   (size_r),
		.best_center_nxt (center_r)
	);

	cbd_lane #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_lane_g (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl_g),
		.col             (col),
		.best_size_nxt   (size_g),
		.best_center_nxt (center_g)
	);

	cbd_lane #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_lane_b (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl_b),
		.col             (col),
		.best_size_nxt   (size_b),
		.best_center_nxt (center_b)
	);

	// cut sizes and centers to the output field widths
	always_comb begin
		res_in.red_size     = cbd_pkg::SIZE_W'(size_r);
		res_in.green_size   = cbd_pkg::SIZE_W'(size_g);
		res_in.blue_size    = cbd_pkg::SIZE_W'(size_b);
		res_in.red_center   = cbd_pkg::CENTER_W'(center_r);
		res_in.green_center = cbd_pkg::CENTER_W'(center_g);
		res_in.blue_center  = cbd_pkg::CENTER_W'(center_b);
	end

	cbd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept && s_tlast),
		.in_ready  (buf_ready),
		.in_data   (res_in),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_out)
	);

	assign m_tdata = cbd_pkg::M_DATA_W'(res_out);

endmodule

[rtl/core/cbd_checker.sv]
// ----------------------------------------------------------------------------
// cbd_checker: port-level checks for the color run detector
// Watches the stream ports and flags result and flow-control slips.
// ----------------------------------------------------------------------------
module cbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// a result waiting on the sink is not withdrawn
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a row end is always followed by a valid result, its own or an older one
	a_row_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> m_tvalid)
		else $error("row end produced no result");

	// pixels inside a row never invent a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && s_tvalid && s_tready && !s_tlast |=> !m_tvalid)
		else $error("result without row end");

	// input stalls only while results back up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// a red lane with no run reports red center zero
	a_empty_center: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[6:0] == 7'd0) |-> (m_tdata[26:21] == 6'd0))
		else $error("red center set without a red run");

endmodule

bind color_run_blob_detector cbd_checker u_cbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/tb_color_run_blob_detector.sv]
// ----------------------------------------------------------------------------
// tb_color_run_blob_detector: self-checking bench for the color run detector
// Streams RGB scan rows into the block, predicts the longest run and its center
// per color for every row, and compares each result item field by field while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_color_run_blob_detector;

	localparam int unsigned ROW_MAX = 64;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         cfg_wen  = 1'b0;
	logic [7:0]                   cfg_wdata = 8'd0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [23:0]                  s_tdata  = 24'd0;   // red[7:0], green[15:8], blue[23:16]
	logic                         s_tlast  = 1'b0;    // last_in_row
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	// red_size, green_size, blue_size, red_center, green_center, blue_center, pad
	logic [cbd_pkg::M_DATA_W-1:0] m_tdata;

	color_run_blob_detector #(
		.MAX_ROW_WIDTH(ROW_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Row tracker: own copy of the threshold and of all per-row state
	// ------------------------------------------------------------------------
	logic [7:0]                   thresh;
	logic [cbd_pkg::SIZE_W-1:0]   col_cnt;
	cbd_pkg::color_t              last_seen;
	logic [cbd_pkg::SIZE_W-1:0]   run_len  [3];
	logic [cbd_pkg::CENTER_W-1:0] run_lo   [3];
	logic [cbd_pkg::CENTER_W-1:0] run_hi   [3];
	logic [cbd_pkg::SIZE_W-1:0]   best_len [3];
	logic [cbd_pkg::CENTER_W-1:0] best_mid [3];

	cbd_pkg::result_t row_result_q [$];

	// Bench bookkeeping
	int error_count   = 0;
	int pixels_sent   = 0;
	int rows_checked  = 0;
	int thresh_writes = 0;

	// Sender and receiver idling controls
	bit src_gaps    = 1'b0;
	int burst_left  = 0;
	bit sink_stalls = 1'b0;
	bit sink_on     = 1'b1;
	int sink_left   = 0;
	int sink_hold   = 0;
	int stall_seen  = 0;

	task clear_row_state();
		col_cnt   = '0;
		last_seen = cbd_pkg::COLOR_NONE;
		for (int c = 0; c < 3; c++) begin
			run_len[c]  = '0;
			run_lo[c]   = '0;
			run_hi[c]   = '0;
			best_len[c] = '0;
			best_mid[c] = '0;
		end
	endtask

	// Advance the tracker by one accepted pixel; queue the row summary on the
	// last pixel of the row.
	task track_pixel(input logic [23:0] px, input logic eol);
		logic [7:0]                   ch [3];
		logic [cbd_pkg::CENTER_W-1:0] col;
		logic                         any_bright;
		logic [cbd_pkg::CENTER_W:0]   mid_sum;
		cbd_pkg::result_t             want;
		ch[0] = px[7:0];
		ch[1] = px[15:8];
		ch[2] = px[23:16];
		// past the row width every pixel sits on the last column
		col = (col_cnt < ROW_MAX) ? col_cnt[cbd_pkg::CENTER_W-1:0]
			: cbd_pkg::CENTER_W'(ROW_MAX - 1);
		any_bright = 1'b0;
		// handle red, green, blue in turn: of several bright channels only the first may continue its run
		for (int c = 0; c < 3; c++) begin
			if (ch[c] >= thresh) begin
				any_bright = 1'b1;
				if (last_seen == cbd_pkg::color_t'(c)) begin
					if (run_len[c] < ROW_MAX)
						run_len[c] = run_len[c] + 1'b1;
					if (col > run_hi[c])
						run_hi[c] = col;
					if (col < run_lo[c])
						run_lo[c] = col;
				end else begin
					run_len[c] = cbd_pkg::SIZE_W'(1);
					run_lo[c]  = col;
					run_hi[c]  = col;
					last_seen  = cbd_pkg::color_t'(c);
				end
				if (best_len[c] < run_len[c]) begin
					best_len[c] = run_len[c];
					mid_sum     = {1'b0, run_lo[c]} + {1'b0, run_hi[c]};
					best_mid[c] = mid_sum[cbd_pkg::CENTER_W:1];
				end
			end
		end
		// a dark pixel breaks every run
		if (!any_bright)
			last_seen = cbd_pkg::COLOR_NONE;
		if (col_cnt < ROW_MAX)
			col_cnt = col_cnt + 1'b1;
		if (eol) begin
			want.red_size     = best_len[0];
			want.green_size   = best_len[1];
			want.blue_size    = best_len[2];
			want.red_center   = best_mid[0];
			want.green_center = best_mid[1];
			want.blue_center  = best_mid[2];
			row_result_q.push_back(want);
			clear_row_state();
		end
	endtask

	// ------------------------------------------------------------------------
	// Result checker: compare every accepted result item with the oldest row
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		cbd_pkg::result_t got;
		cbd_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = cbd_pkg::result_t'(m_tdata[cbd_pkg::RESULT_W-1:0]);
			if (row_result_q.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("ERROR: result item with no row pending: %h", m_tdata);
			end else begin
				want = row_result_q.pop_front();
				rows_checked++;
				if (got.red_size != want.red_size || got.green_size != want.green_size ||
					got.blue_size != want.blue_size || got.red_center != want.red_center ||
					got.green_center != want.green_center ||
					got.blue_center != want.blue_center ||
					m_tdata[cbd_pkg::M_DATA_W-1:cbd_pkg::RESULT_W] != '0) begin
					error_count++;
					if (error_count <= 10)
						$display({"ERROR: row %0d size r/g/b exp %0d/%0d/%0d got %0d/%0d/%0d,",
							" center exp %0d/%0d/%0d got %0d/%0d/%0d, pad %b"},
							rows_checked, want.red_size, want.green_size, want.blue_size,
							got.red_size, got.green_size, got.blue_size,
							want.red_center, want.green_center, want.blue_center,
							got.red_center, got.green_center, got.blue_center,
							m_tdata[cbd_pkg::M_DATA_W-1:cbd_pkg::RESULT_W]);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: long hold-off on request, else always ready or its own stall pattern
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			m_tready  <= 1'b0;
			sink_hold = sink_hold - 1;
		end else if (!sink_stalls) begin
			m_tready <= 1'b1;
		end else begin
			if (sink_left == 0) begin
				sink_on   = !sink_on;
				sink_left = sink_on ? $urandom_range(1, 10) : $urandom_range(1, 6);
			end
			sink_left = sink_left - 1;
			m_tready <= sink_on;
		end
	end

	// Count cycles where the block refused an offered item
	always @(posedge clk)
		if (arst_n && s_tvalid && !s_tready)
			stall_seen++;

	// ------------------------------------------------------------------------
	// Sender and configuration helpers
	// ------------------------------------------------------------------------
	// Offer one pixel and hold it until accepted; gaps fall between bursts.
	task send_pixel(input logic [23:0] px, input logic eol);
		int gap;
		if (src_gaps && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		s_tlast  <= eol;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_pixel(px, eol);
		pixels_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// Drop valid and hold until every queued row result has come back.
	task drain_rows();
		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		while (row_result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the threshold only once the block has gone idle.
	task set_threshold(input logic [7:0] value);
		drain_rows();
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		thresh = value;
		thresh_writes++;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [7:0] bright_level();
		return 8'($urandom_range(thresh, 255));
	endfunction

	function automatic logic [7:0] dark_level();
		return (thresh == 0) ? 8'd0 : 8'($urandom_range(0, thresh - 1));
	endfunction

	// One row built from segments: mostly solid single-color runs, with dark
	// gaps, multi-bright pixels and fully random noise mixed in.
	task automatic send_random_row(input int len);
		int         seg_left;
		int         kind;
		logic [1:0] pick;
		logic [2:0] mask;
		logic [7:0] ch [3];
		seg_left = 0;
		kind     = 0;
		pick     = 2'd0;
		mask     = 3'd0;
		for (int i = 0; i < len; i++) begin
			if (seg_left == 0) begin
				kind     = $urandom_range(0, 9);
				pick     = 2'($urandom_range(0, 2));
				mask     = 3'($urandom_range(1, 7));
				seg_left = $urandom_range(1, 12);
			end
			seg_left--;
			for (int c = 0; c < 3; c++) begin
				if (kind == 9)
					ch[c] = 8'($urandom);
				else if (kind <= 5)
					ch[c] = (c == pick) ? bright_level() : dark_level();
				else if (kind <= 7)
					ch[c] = dark_level();
				else
					ch[c] = mask[c] ? bright_level() : dark_level();
			end
			send_pixel({ch[2], ch[1], ch[0]}, i == len - 1);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Reset threshold boundary, multi-bright restarts, dark breaks, tiny rows,
	// and the threshold extremes 0 and 255.
	task test_directed();
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		// default threshold: 249 is dark, 250 is bright
		send_pixel({8'd0,   8'd0,   8'd250}, 1'b0);
		send_pixel({8'd0,   8'd0,   8'd255}, 1'b0);
		send_pixel({8'd249, 8'd249, 8'd249}, 1'b0);
		send_pixel({8'd0,   8'd0,   8'd255}, 1'b0);
		send_pixel({8'd255, 8'd255, 8'd255}, 1'b0);
		send_pixel({8'd255, 8'd255, 8'd0},   1'b0);
		send_pixel({8'd255, 8'd0,   8'd0},   1'b0);
		send_pixel({8'd0,   8'd0,   8'd0},   1'b1);
		// single-pixel row, all bright
		send_pixel({8'd255, 8'd255, 8'd255}, 1'b1);
		// row with no bright pixel: sizes and centers stay zero
		send_pixel({8'd0,   8'd0,   8'd0},   1'b1);
		// threshold 0: every channel is bright
		set_threshold(8'd0);
		send_pixel({8'd0,   8'd0,   8'd0},   1'b0);
		send_pixel({8'd0,   8'd0,   8'd0},   1'b1);
		// threshold 255: only full scale counts
		set_threshold(8'd255);
		send_pixel({8'd254, 8'd255, 8'd254}, 1'b0);
		send_pixel({8'd255, 8'd255, 8'd255}, 1'b0);
		send_pixel({8'd0,   8'd255, 8'd0},   1'b1);
		send_pixel({8'd255, 8'd254, 8'd255}, 1'b1);
	endtask

	// Rows at, just past and far past the column limit.
	task test_row_overflow();
		set_threshold(8'd250);
		for (int i = 0; i < ROW_MAX; i++)
			send_pixel({8'd0, 8'd255, 8'd0}, i == ROW_MAX - 1);
		for (int i = 0; i < ROW_MAX + 1; i++)
			send_pixel({8'd0, 8'd0, 8'd255}, i == ROW_MAX);
		// a short red run, then blue running off the end of the row
		for (int i = 0; i < ROW_MAX + 30; i++)
			send_pixel((i < 5) ? 24'h0000ff : 24'hff0000, i == ROW_MAX + 29);
	endtask

	// Hold the receiver off for a long stretch while short rows keep coming,
	// so the output stage fills and the input stalls; then let it all drain.
	task test_backpressure();
		drain_rows();
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		sink_hold   = 300;
		for (int r = 0; r < 30; r++)
			send_random_row($urandom_range(1, 2));
		drain_rows();
	endtask

	// Random rows over several thresholds and idling mixes; pause midway
	// until every pending row has come back.
	task test_random_rows();
		int         target;
		int         len;
		logic [7:0] th_list [6];
		th_list[0] = 8'd0;
		th_list[1] = 8'd255;
		th_list[2] = 8'd128;
		th_list[3] = 8'($urandom_range(1, 254));
		th_list[4] = cbd_pkg::THRESH_RESET;
		th_list[5] = 8'($urandom);
		for (int p = 0; p < 6; p++) begin
			set_threshold(th_list[p]);
			src_gaps    = (p % 3) != 0;
			sink_stalls = (p % 2) != 0;
			target      = pixels_sent + 185;
			while (pixels_sent < target) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 90)
					: $urandom_range(1, 40);
				send_random_row(len);
				if (pixels_sent > target - 120 && pixels_sent < target - 80)
					drain_rows();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		thresh = cbd_pkg::THRESH_RESET;
		clear_row_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_row_overflow();
		test_backpressure();
		test_random_rows();

		drain_rows();
		repeat (10) @(posedge clk);
		$display("Sent %0d pixels, checked %0d rows over %0d threshold writes.",
			pixels_sent, rows_checked, thresh_writes);
		$display("Input stalled on %0d cycles; %0d mismatches.", stall_seen, error_count);
		if (error_count == 0 && row_result_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule
